@@ rtl/spool_chunk_filter_defines.svh @@
// Assertion macros shared by the spool chunk filter RTL.
`ifndef SPOOL_CHUNK_FILTER_DEFINES_SVH
`define SPOOL_CHUNK_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/scf_pkg.sv @@
// Shared types and constants of the spool chunk filter.
package scf_pkg;

  localparam int COUNT_BITS     = 24;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] CMD_MASK      = 32'hf000_0000;
  localparam logic [31:0] END_MODEL0    = 32'hffff_fff3;
  localparam logic [31:0] END_MODEL1    = 32'hffff_fff7;
  localparam logic [31:0] END_MODEL2_A  = 32'hffff_fff8;
  localparam logic [31:0] END_MODEL2_B  = 32'hffff_fff4;
  localparam logic [31:0] SKIP_LOW      = 32'hffff_ffeb;
  localparam logic [31:0] SKIP_HIGH     = 32'hffff_ffef;
  localparam logic [31:0] SKIP_EXTRA    = 32'hffff_fff5;
  localparam logic [7:0]  ESC_BYTE      = 8'h1b;
  localparam logic [7:0]  COPIES_TAG    = 8'hee;
  localparam logic [COUNT_BITS-1:0] PATCH_OFS_COMPACT = COUNT_BITS'(8);
  localparam logic [COUNT_BITS-1:0] PATCH_OFS_OTHER   = COUNT_BITS'(12);
  localparam logic [27:0] SKIP_ARG_LEN  = 28'd4;

  typedef enum logic [1:0] {
    MODEL_PHOTO   = 2'd0,
    MODEL_COMPACT = 2'd1,
    MODEL_MEDICAL = 2'd2,
    MODEL_NONE    = 2'd3
  } scf_model_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_EMPTY   = 2'd3
  } scf_kind_t;

  typedef enum logic {
    REG_PRINTER_MODEL = 1'b0,
    REG_COPIES_VALUE  = 1'b1
  } scf_reg_t;

  // One queue entry: up to four result beats of the same kind.
  typedef struct packed {
    logic [3:0][7:0] data;
    scf_kind_t       kind;
    logic [1:0]      last_idx;
  } scf_entry_t;

endpackage

@@ rtl/spool_chunk_filter.sv @@
// A result beat passes through a queue slot register and then the output register.
// One input beat is taken per cycle while the queue is not full; a chunk header gives four result
// beats in one entry of a four-entry queue between front and back; the output port gives one beat
// a cycle while out_stall is low. Input stalls only while that queue is full.
// Reset (synchronous, rst high) clears all job state, sets printer_model to 0 and
// copies_value to 1; no clearing pass follows.
module spool_chunk_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  byte_kind,
  output logic        last
);

  logic [1:0] printer_model;
  logic [7:0] copies_value;
  logic       cfg_write;

  logic                q_full, q_empty, q_push, q_pop;
  scf_pkg::scf_entry_t q_in, q_head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      printer_model <= 2'd0;
      copies_value  <= 8'd1;
    end else if (cfg_write) begin
      case (scf_pkg::scf_reg_t'(paddr[2]))
        scf_pkg::REG_PRINTER_MODEL: printer_model <= pwdata[1:0];
        scf_pkg::REG_COPIES_VALUE:  copies_value  <= pwdata[7:0];
        default:                    printer_model <= printer_model;
      endcase
    end
  end

  always_comb begin
    case (scf_pkg::scf_reg_t'(paddr[2]))
      scf_pkg::REG_PRINTER_MODEL: prdata = 32'(printer_model);
      scf_pkg::REG_COPIES_VALUE:  prdata = 32'(copies_value);
      default:                    prdata = '0;
    endcase
  end

  scf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .printer_model (printer_model),
    .copies_value  (copies_value),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_input  (end_of_input),
    .q_full        (q_full),
    .push          (q_push),
    .entry         (q_in)
  );

  scf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .head       (q_head)
  );

  scf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .byte_kind (byte_kind),
    .last      (last)
  );

endmodule

@@ rtl/scf_front.sv @@
// Front end: parses headers, tracks payloads and patches, builds queue entries.
`include "spool_chunk_filter_defines.svh"

module scf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          printer_model,
  input  logic [7:0]          copies_value,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                end_of_input,
  input  logic                q_full,
  output logic                push,
  output scf_pkg::scf_entry_t entry
);

  localparam int CB = scf_pkg::COUNT_BITS;

  logic [31:0]   header_shift, header_shift_next;
  logic [1:0]    header_count, header_count_next;
  logic [27:0]   bytes_remaining, bytes_remaining_next;
  logic          keep_chunk, keep_chunk_next;
  logic [1:0]    payload_position, payload_position_next;
  logic          first_was_escape, first_was_escape_next;
  logic [CB-1:0] chunk_start_count, chunk_start_count_next;
  logic [CB-1:0] kept_count, kept_count_next;
  logic [CB-1:0] patch_target, patch_target_next;
  logic          patch_armed, patch_armed_next;
  logic          job_stopped, job_stopped_next;

  logic          accept;
  logic [31:0]   word;
  logic [CB-1:0] arm_target;
  logic [CB-1:0] patch_dist;
  logic          is_end, is_skip;
  logic          pay_armed;
  logic [CB-1:0] pay_target;
  logic          pay_hit;
  scf_pkg::scf_kind_t status_kind;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign word     = {in_byte, header_shift[31:8]};

  assign arm_target = chunk_start_count +
      ((printer_model == scf_pkg::MODEL_COMPACT) ? scf_pkg::PATCH_OFS_COMPACT
                                                 : scf_pkg::PATCH_OFS_OTHER);
  assign patch_dist  = patch_target - kept_count;
  assign status_kind = (kept_count != '0) ? scf_pkg::KIND_DONE : scf_pkg::KIND_EMPTY;

  always_comb begin
    case (printer_model)
      scf_pkg::MODEL_PHOTO:   is_end = (word == scf_pkg::END_MODEL0);
      scf_pkg::MODEL_COMPACT: is_end = (word == scf_pkg::END_MODEL1);
      scf_pkg::MODEL_MEDICAL: is_end = (word == scf_pkg::END_MODEL2_A) ||
                                       (word == scf_pkg::END_MODEL2_B);
      default:                is_end = 1'b0;
    endcase
  end

  assign is_skip = ((word >= scf_pkg::SKIP_LOW) && (word <= scf_pkg::SKIP_HIGH)) ||
                   (word == scf_pkg::SKIP_EXTRA);

  // Arming on the second payload byte takes effect before that byte is kept.
  always_comb begin
    pay_armed  = patch_armed;
    pay_target = patch_target;
    if (payload_position == 2'd1 && first_was_escape && in_byte == scf_pkg::COPIES_TAG) begin
      pay_armed  = 1'b1;
      pay_target = arm_target;
    end
  end
  assign pay_hit = pay_armed && (kept_count == pay_target);

  always_comb begin
    header_shift_next      = header_shift;
    header_count_next      = header_count;
    bytes_remaining_next   = bytes_remaining;
    keep_chunk_next        = keep_chunk;
    payload_position_next  = payload_position;
    first_was_escape_next  = first_was_escape;
    chunk_start_count_next = chunk_start_count;
    kept_count_next        = kept_count;
    patch_target_next      = patch_target;
    patch_armed_next       = patch_armed;
    job_stopped_next       = job_stopped;
    push                   = 1'b0;
    entry                  = '0;

    if (accept) begin
      if (end_of_input) begin
        if (!job_stopped) begin
          push       = 1'b1;
          entry.kind = status_kind;
        end
        header_shift_next      = '0;
        header_count_next      = '0;
        bytes_remaining_next   = '0;
        keep_chunk_next        = 1'b0;
        payload_position_next  = '0;
        first_was_escape_next  = 1'b0;
        chunk_start_count_next = '0;
        kept_count_next        = '0;
        patch_target_next      = '0;
        patch_armed_next       = 1'b0;
        job_stopped_next       = 1'b0;
      end else if (job_stopped) begin
        push = 1'b0;
      end else if (bytes_remaining != '0) begin
        if (payload_position == 2'd0) begin
          first_was_escape_next = (in_byte == scf_pkg::ESC_BYTE);
          payload_position_next = 2'd1;
        end else if (payload_position == 2'd1) begin
          payload_position_next = 2'd2;
        end
        patch_armed_next  = pay_armed;
        patch_target_next = pay_target;
        if (keep_chunk) begin
          push          = 1'b1;
          entry.kind    = scf_pkg::KIND_PAYLOAD;
          entry.data[0] = pay_hit ? copies_value : in_byte;
          if (pay_hit) begin
            patch_armed_next = 1'b0;
          end
          kept_count_next = kept_count + CB'(1);
        end
        bytes_remaining_next = bytes_remaining - 28'd1;
      end else begin
        header_shift_next = word;
        if (header_count != 2'd3) begin
          header_count_next = header_count + 2'd1;
        end else begin
          header_count_next = '0;
          if ((word & scf_pkg::CMD_MASK) != '0) begin
            if (is_end) begin
              push             = 1'b1;
              entry.kind       = status_kind;
              job_stopped_next = 1'b1;
            end else if (is_skip) begin
              bytes_remaining_next   = scf_pkg::SKIP_ARG_LEN;
              keep_chunk_next        = 1'b0;
              payload_position_next  = '0;
              first_was_escape_next  = 1'b0;
              chunk_start_count_next = kept_count;
            end
          end else begin
            push           = 1'b1;
            entry.kind     = scf_pkg::KIND_HEADER;
            entry.last_idx = 2'd3;
            entry.data     = word;
            // Patch the header byte that lands on the target, if any.
            if (patch_armed && patch_dist[CB-1:2] == '0) begin
              entry.data[patch_dist[1:0]] = copies_value;
              patch_armed_next            = 1'b0;
            end
            kept_count_next        = kept_count + CB'(4);
            bytes_remaining_next   = word[27:0];
            keep_chunk_next        = 1'b1;
            payload_position_next  = '0;
            first_was_escape_next  = 1'b0;
            chunk_start_count_next = kept_count + CB'(4);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_shift      <= '0;
      header_count      <= '0;
      bytes_remaining   <= '0;
      keep_chunk        <= 1'b0;
      payload_position  <= '0;
      first_was_escape  <= 1'b0;
      chunk_start_count <= '0;
      kept_count        <= '0;
      patch_target      <= '0;
      patch_armed       <= 1'b0;
      job_stopped       <= 1'b0;
    end else begin
      header_shift      <= header_shift_next;
      header_count      <= header_count_next;
      bytes_remaining   <= bytes_remaining_next;
      keep_chunk        <= keep_chunk_next;
      payload_position  <= payload_position_next;
      first_was_escape  <= first_was_escape_next;
      chunk_start_count <= chunk_start_count_next;
      kept_count        <= kept_count_next;
      patch_target      <= patch_target_next;
      patch_armed       <= patch_armed_next;
      job_stopped       <= job_stopped_next;
    end
  end

  `SCF_ASSERT_NOW(a_hdr_not_in_payload, header_count != 2'd0, bytes_remaining == '0, "header count moved during payload")
  `SCF_ASSERT_NOW(a_stopped_hdr_idle, job_stopped, header_count == 2'd0 && bytes_remaining == '0, "stopped job holds parse state")

endmodule

@@ rtl/scf_queue.sv @@
// Short register queue of result entries between front and back.
`include "spool_chunk_filter_defines.svh"

module scf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  scf_pkg::scf_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output scf_pkg::scf_entry_t head
);

  localparam int PB = scf_pkg::QUEUE_PTR_BITS;
  localparam int NB = scf_pkg::QUEUE_CNT_BITS;

  scf_pkg::scf_entry_t slots [scf_pkg::QUEUE_DEPTH];
  logic [PB-1:0] wr_ptr, rd_ptr;
  logic [NB-1:0] count;

  assign full  = (count == NB'(scf_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PB'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PB'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + NB'(1);
        2'b01:   count <= count - NB'(1);
        default: count <= count;
      endcase
    end
  end

  `SCF_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
  `SCF_ASSERT_NOW(a_no_pop_empty, pop, !empty, "pop from empty queue")
  `SCF_ASSERT_NEXT(a_push_fills, push && !pop && !full, !empty, "pushed entry lost")

endmodule

@@ rtl/scf_back.sv @@
// Back end: walks queue entries beat by beat into the output register.
`include "spool_chunk_filter_defines.svh"

module scf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  scf_pkg::scf_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic [1:0]          byte_kind,
  output logic                last
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = !out_valid || !out_stall;
  assign at_end = (idx == head.last_idx);
  assign pop    = load && !q_empty && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= at_end ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Payload of the output register; hold while stalled.
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_byte  <= head.data[idx];
      byte_kind <= head.kind;
      last      <= at_end;
    end
  end

  `SCF_ASSERT_NOW(a_mid_entry_head, idx != 2'd0, !q_empty, "entry left while beats remain")

endmodule
